// ===== hdl/avt_pkg.sv =====
// Shared types, widths and constants for the affine vertex transform.
package avt_pkg;

  localparam int unsigned QW        = 32;  // Q16.16 word width
  localparam int unsigned FRAC      = 16;  // fraction bits
  localparam int unsigned NUM_COMP  = 4;   // vertex components / matrix columns
  localparam int unsigned NUM_ROWS  = 4;   // output rows, one lane each
  localparam int unsigned NUM_REGS  = 8;   // two registers per column
  localparam int unsigned CFG_IDX_W = 4;   // room to see out-of-range writes
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned PROD_W    = 2 * QW;        // one exact product
  localparam int unsigned PAIR_W    = PROD_W + 1;    // sum of two products
  localparam int unsigned SUM_W     = PROD_W + 2;    // sum of four products
  localparam int unsigned SHR_W     = SUM_W - FRAC;  // sum after the shift

  // Mode codes on in_func; the unused code behaves as homogeneous.
  localparam logic [1:0] FUNC_HOMOG = 2'd0;
  localparam logic [1:0] FUNC_POS   = 2'd1;
  localparam logic [1:0] FUNC_DIR   = 2'd2;

  localparam logic signed [QW-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [QW-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN   = 32'sh8000_0000;

  typedef logic signed [QW-1:0]     q16_t;
  typedef q16_t [NUM_COMP-1:0]      vec4_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef pair_t [1:0]              pair2_t;
  typedef logic [CFG_DW-1:0]        cfg_word_t;

  // Register reset values: identity matrix.
  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

endpackage

// ===== hdl/avt_lane.sv =====
// One row lane: four signed products, then two pair sums, both registered.
module avt_lane (
  input  logic                 clk,
  input  avt_pkg::vec4_t       vec_i,
  input  avt_pkg::vec4_t       ent_i,
  output avt_pkg::pair2_t      pair_o
);

  avt_pkg::prod_t [avt_pkg::NUM_COMP-1:0] prod_r;
  avt_pkg::pair2_t                        pair_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < avt_pkg::NUM_COMP; c++) begin
      prod_r[c] <= $signed(vec_i[c]) * $signed(ent_i[c]);
    end
  end

  // Sign-extend and add pairwise.
  always_ff @(posedge clk) begin
    pair_r[0] <= avt_pkg::pair_t'($signed(prod_r[0])) + avt_pkg::pair_t'($signed(prod_r[1]));
    pair_r[1] <= avt_pkg::pair_t'($signed(prod_r[2])) + avt_pkg::pair_t'($signed(prod_r[3]));
  end

  assign pair_o = pair_r;

endmodule

// ===== hdl/avt_merge.sv =====
// Merge stage: final row sums, floor shift, saturation, output register.
module avt_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     valid_i,
  input  avt_pkg::pair2_t [avt_pkg::NUM_ROWS-1:0]  pair_i,
  output logic                                     valid_o,
  output avt_pkg::vec4_t                           res_o
);

  logic                                    valid_r;
  avt_pkg::vec4_t                          res_r;
  avt_pkg::vec4_t                          res_nxt;
  logic signed [avt_pkg::SUM_W-1:0]        sum   [avt_pkg::NUM_ROWS];
  logic signed [avt_pkg::SHR_W-1:0]        shr   [avt_pkg::NUM_ROWS];

  always_comb begin
    for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
      sum[r] = (avt_pkg::SUM_W)'($signed(pair_i[r][0]))
             + (avt_pkg::SUM_W)'($signed(pair_i[r][1]));
      // Arithmetic shift drops fraction bits: floor toward minus infinity.
      shr[r] = sum[r][avt_pkg::SUM_W-1:avt_pkg::FRAC];
      if (shr[r][avt_pkg::SHR_W-1:avt_pkg::QW-1] == '0 ||
          shr[r][avt_pkg::SHR_W-1:avt_pkg::QW-1] == '1) begin
        res_nxt[r] = shr[r][avt_pkg::QW-1:0];
      end else if (shr[r][avt_pkg::SHR_W-1]) begin
        res_nxt[r] = avt_pkg::Q_MIN;
      end else begin
        res_nxt[r] = avt_pkg::Q_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule

// ===== hdl/affine_vertex_transform_4x4.sv =====
// Top level: affine 4x4 vertex transform with four row lanes and a merge stage.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ------------------------------
//  input    in_func in_x in_y in_z in_w             beat when start && !busy
//  result   out_x out_y out_z out_w                 beat on out_valid, one cycle
//  config   cfg_index cfg_data                      beat when cfg_valid && cfg_ready
//
// One vertex enters per clock while busy is low; busy is high during reset and the
// first cycle after. Products are registered at the accept edge, then the pair sums,
// then the merge result; out_valid rises with the merge result register.
// Every lane owns four 32x32 multipliers, so nothing is shared between beats.
// Reset loads the identity matrix and empties the pipeline.
// The receiver cannot stall; no result is ever held back.
module affine_vertex_transform_4x4 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic signed [31:0]             in_x,
  input  logic signed [31:0]             in_y,
  input  logic signed [31:0]             in_z,
  input  logic signed [31:0]             in_w,
  output logic                           out_valid,
  output logic signed [31:0]             out_x,
  output logic signed [31:0]             out_y,
  output logic signed [31:0]             out_z,
  output logic signed [31:0]             out_w,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [avt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [avt_pkg::CFG_DW-1:0]     cfg_data
);

  logic                                    busy_r;
  logic                                    accept;
  logic                                    cfg_in_range;
  logic                                    prod_vld_r;
  logic                                    pair_vld_r;
  avt_pkg::cfg_word_t                      cfg_r [avt_pkg::NUM_REGS];
  avt_pkg::vec4_t                          vec;
  avt_pkg::q16_t                           w_eff;
  avt_pkg::vec4_t  [avt_pkg::NUM_ROWS-1:0] ent;
  avt_pkg::pair2_t [avt_pkg::NUM_ROWS-1:0] pair;
  avt_pkg::vec4_t                          res;

  // Hold busy through reset only; drop it on the first clock after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy         = busy_r;
  assign cfg_ready    = !busy_r;
  assign accept       = start && !busy_r;
  assign cfg_in_range = cfg_index < avt_pkg::CFG_IDX_W'(avt_pkg::NUM_REGS);

  // Matrix registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < avt_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= avt_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && cfg_in_range) begin
      cfg_r[cfg_index[$clog2(avt_pkg::NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  // Effective w from the mode; the unused code takes in_w like homogeneous.
  always_comb begin
    unique case (in_func)
      avt_pkg::FUNC_POS: w_eff = avt_pkg::ONE_Q16;
      avt_pkg::FUNC_DIR: w_eff = '0;
      default:           w_eff = in_w;
    endcase
  end

  assign vec = {w_eff, in_z, in_y, in_x};

  // Column c, row r lives in register 2c + r/2, low half for even rows.
  always_comb begin
    for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < avt_pkg::NUM_COMP; c++) begin
        ent[r][c] = (r % 2 == 1) ? cfg_r[2 * c + r / 2][2*avt_pkg::QW-1:avt_pkg::QW]
                                 : cfg_r[2 * c + r / 2][avt_pkg::QW-1:0];
      end
    end
  end

  // Advance the valid marks alongside the lane registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      pair_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= accept;
      pair_vld_r <= prod_vld_r;
    end
  end

  for (genvar r = 0; r < avt_pkg::NUM_ROWS; r++) begin : g_lane
    avt_lane u_lane (
      .clk    (clk),
      .vec_i  (vec),
      .ent_i  (ent[r]),
      .pair_o (pair[r])
    );
  end

  avt_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (pair_vld_r),
    .pair_i  (pair),
    .valid_o (out_valid),
    .res_o   (res)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

  // Every accepted beat leaves as a result, and nothing else does.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted vertex did not produce a result");

  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result without a matching accepted vertex");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == '0) |=> (cfg_r[0] == $past(cfg_data)))
    else $error("configuration write to register 0 was lost");

endmodule
